@@ rtl/core/kcm_pkg.sv @@
// Shared types and constants for the k-means centroid merge block.
// Used by the front end, the job queue, the divider back end and the top level.
package kcm_pkg;

  localparam int MAX_LANES = 8;
  localparam int LANE_W    = 32;
  localparam int IN_W      = MAX_LANES * LANE_W;
  localparam int CNT_W     = 16;
  localparam int PT_W      = 20;
  localparam int SUM_W     = 36;
  localparam int NUM_W     = 37;
  localparam int MAG_W     = 36;
  localparam int DIV_CNT_W = 6;
  localparam int OUT_W     = 80;

  // Beat positions within one cluster record.
  localparam logic [2:0] SLOT_OLD_X = 3'd0;
  localparam logic [2:0] SLOT_OLD_Y = 3'd1;
  localparam logic [2:0] SLOT_COUNT = 3'd3;
  localparam logic [2:0] SLOT_SUM_X = 3'd5;
  localparam logic [2:0] SLOT_SUM_Y = 3'd6;
  localparam logic [2:0] SLOT_LAST  = 3'd7;

  // One merge job handed from the front end to the divider.
  typedef struct packed {
    logic [CNT_W-1:0]        index;
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [PT_W-1:0]  total;
    logic                    last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SEND
  } back_state_t;

endpackage

@@ rtl/core/kcm_front.sv @@
// Front end: accepts beats, tracks the record position and forms merge jobs.
// Depends on kcm_pkg.
module kcm_front import kcm_pkg::*; #(
  parameter int LANES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic [2:0]              slot_r;
  logic [CNT_W-1:0]        counter_r;
  logic [CNT_W-1:0]        count_cfg_r;
  logic signed [LANE_W-1:0] old_x_r, old_y_r;
  logic signed [PT_W-1:0]  total_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic signed [SUM_W-1:0] lane_sum;
  logic signed [PT_W-1:0]  int_sum;
  logic                    accept;
  logic                    last;

  // Lane sums: full words and integer parts truncated toward zero.
  always_comb begin
    logic signed [LANE_W-1:0] w;
    logic signed [LANE_W:0]   wb;
    lane_sum = '0;
    int_sum  = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      w  = in_tdata[i*LANE_W +: LANE_W];
      wb = {w[LANE_W-1], w} + (w[LANE_W-1] ? 33'sd65535 : 33'sd0);
      if (i < LANES) begin
        lane_sum = lane_sum + SUM_W'(w);
        int_sum  = int_sum + PT_W'($signed(wb[LANE_W:16]));
      end
    end
  end

  assign in_tready = (slot_r != SLOT_LAST) || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign last      = (counter_r == CNT_W'(count_cfg_r - 1'b1));
  assign q_push    = accept && (slot_r == SLOT_LAST);

  // Job contents come from the stored record fields and the cluster counter.
  always_comb begin
    q_job.index = counter_r;
    q_job.num_x = NUM_W'(old_x_r) + NUM_W'(sum_x_r);
    q_job.num_y = NUM_W'(old_y_r) + NUM_W'(sum_y_r);
    q_job.total = total_r;
    q_job.last  = last;
  end

  // Control state: record position, cluster counter and the run length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      counter_r   <= '0;
      count_cfg_r <= CNT_W'(1);
    end else begin
      if (cfg_wr_en) count_cfg_r <= cfg_wr_data;
      if (accept) slot_r <= slot_r + 3'd1;
      if (q_push) counter_r <= last ? '0 : counter_r + 1'b1;
    end
  end

  // Record fields captured on their beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_x_r <= '0;
      old_y_r <= '0;
      total_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (accept) begin
      case (slot_r)
        SLOT_OLD_X: old_x_r <= in_tdata[LANE_W-1:0];
        SLOT_OLD_Y: old_y_r <= in_tdata[LANE_W-1:0];
        SLOT_COUNT: total_r <= int_sum - PT_W'(LANES - 1);
        SLOT_SUM_X: sum_x_r <= lane_sum;
        SLOT_SUM_Y: sum_y_r <= lane_sum;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/kcm_queue.sv @@
// Two-entry job queue between the front end and the divider back end.
// Depends on kcm_pkg.
module kcm_queue import kcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign pop_job   = mem_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue fill level out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/kcm_back.sv @@
// Back end: restoring divider for x and y in parallel, saturation and the
// output register. Depends on kcm_pkg.
module kcm_back import kcm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  back_state_t            state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   step_r;
  logic [MAG_W-1:0]       mag_x_r, mag_y_r;
  logic [PT_W-1:0]        rem_x_r, rem_y_r;
  logic [PT_W-1:0]        den_r;
  logic                   neg_x_r, neg_y_r, empty_r, last_r;
  logic [CNT_W-1:0]       index_r;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;
  logic                   out_user_r, out_last_r;
  logic                   out_free, div_done, send;
  logic [PT_W:0]          sh_x, sh_y, diff_x, diff_y;
  logic [LANE_W-1:0]      res_x, res_y;

  function automatic logic [LANE_W-1:0] sat(input logic neg, input logic [MAG_W-1:0] m);
    logic [LANE_W-1:0] r;
    if (neg) r = (m > 36'h080000000) ? 32'h80000000 : LANE_W'(-m);
    else     r = (m > 36'h07FFFFFFF) ? 32'h7FFFFFFF : m[LANE_W-1:0];
    return r;
  endfunction

  assign out_free = !out_valid_r || out_tready;
  assign div_done = (step_r == DIV_CNT_W'(MAG_W - 1));

  // One quotient bit per cycle for each coordinate.
  assign sh_x   = {rem_x_r, mag_x_r[MAG_W-1]};
  assign sh_y   = {rem_y_r, mag_y_r[MAG_W-1]};
  assign diff_x = sh_x - {1'b0, den_r};
  assign diff_y = sh_y - {1'b0, den_r};

  assign res_x = empty_r ? '0 : sat(neg_x_r, mag_x_r);
  assign res_y = empty_r ? '0 : sat(neg_y_r, mag_y_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid) state_nxt = (job.total <= 0) ? BK_SEND : BK_DIV;
      BK_DIV:  if (div_done) state_nxt = BK_SEND;
      BK_SEND: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    job_pop = 1'b0;
    send    = 1'b0;
    unique case (state_r)
      BK_IDLE: job_pop = job_valid;
      BK_DIV:  ;
      BK_SEND: send = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      neg_x_r <= job.num_x[NUM_W-1];
      neg_y_r <= job.num_y[NUM_W-1];
      mag_x_r <= MAG_W'(job.num_x[NUM_W-1] ? -job.num_x : job.num_x);
      mag_y_r <= MAG_W'(job.num_y[NUM_W-1] ? -job.num_y : job.num_y);
      den_r   <= job.total;
      empty_r <= (job.total <= 0);
      last_r  <= job.last;
      index_r <= job.index;
      rem_x_r <= '0;
      rem_y_r <= '0;
      step_r  <= '0;
    end else if (state_r == BK_DIV) begin
      step_r  <= step_r + 1'b1;
      rem_x_r <= diff_x[PT_W] ? sh_x[PT_W-1:0] : diff_x[PT_W-1:0];
      rem_y_r <= diff_y[PT_W] ? sh_y[PT_W-1:0] : diff_y[PT_W-1:0];
      mag_x_r <= {mag_x_r[MAG_W-2:0], !diff_x[PT_W]};
      mag_y_r <= {mag_y_r[MAG_W-2:0], !diff_y[PT_W]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (send) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_data_r <= {res_y, res_x, index_r};
      out_user_r <= empty_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
      job_pop |-> state_r == BK_IDLE)
    else $error("job taken while busy");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
      send && empty_r |=> out_tdata[79:16] == '0)
    else $error("empty cluster with nonzero center");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == BK_DIV |-> step_r < DIV_CNT_W'(MAG_W))
    else $error("divider ran past its step count");

endmodule

@@ rtl/core/kmeans_centroid_merge.sv @@
// K-means centroid merge: eight beats per cluster record in, one centroid out.
// The result of a record follows its eighth beat through the job queue, the
// divider and the output register; an empty cluster skips the divider.
// A new record is taken only once the 36-step bit-serial divider is done with
// the last one; the two-entry job queue absorbs the following record's beats.
// Reset (rst_n low, synchronous) clears all control state; cluster_count = 1.
module kmeans_centroid_merge import kcm_pkg::*; #(
  parameter int LANES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,  // cluster_count
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,     // lane_0 .. lane_7, 32 bits each
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,    // cluster_index, center_x, center_y
  output logic             out_tuser,    // empty_cluster
  output logic             out_tlast     // last_cluster
);

  logic q_push, q_full, q_pop, q_not_empty;
  job_t push_job, pop_job;

  kcm_front #(.LANES(LANES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_full(q_full), .q_push(q_push), .q_job(push_job)
  );

  kcm_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_job(push_job), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .pop_job(pop_job)
  );

  kcm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(q_not_empty), .job(pop_job), .job_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule
